// File: rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/core/rps_pkg.sv
package rps_pkg;

  localparam int NUM_PORTS   = 16;
  localparam int QUEUE_DEPTH = 64;

  localparam int SLOT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int QIDX_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int USED_W = $clog2(NUM_PORTS + 1);
  localparam int ADDR_W = SLOT_W + QIDX_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam int PORT_W = 16;
  localparam int SEQ_W  = 16;
  localparam int REF_W  = 16;
  localparam int CNT_W  = 7;

  typedef enum logic {
    CMD_RECV  = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_QUEUED  = 3'd0,
    ST_STALE   = 3'd1,
    ST_QFULL   = 3'd2,
    ST_TFULL   = 3'd3,
    ST_DRAINED = 3'd4,
    ST_NOTHING = 3'd5
  } status_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic              known;
    logic              tfull;
    logic [SLOT_W-1:0] slot;
    logic [SEQ_W-1:0]  seq;
    logic [REF_W-1:0]  payload;
  } req_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [REF_W-1:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_INS,
    B_INS0,
    B_DRN,
    B_RES
  } back_state_t;

endpackage

// File: rtl/core/rps_front.sv
module rps_front import rps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cmd_t              in_cmd,
  input  logic [PORT_W-1:0] in_port,
  input  logic [SEQ_W-1:0]  in_seq,
  input  logic [REF_W-1:0]  in_payload,
  input  logic              q_full,
  output logic              q_push,
  output req_t              q_req
);

  logic [NUM_PORTS-1:0] key_vld_r;
  logic [NUM_PORTS-1:0] key_vld_nxt;
  logic [PORT_W-1:0]    key_r [NUM_PORTS];
  logic [USED_W-1:0]    used_r;
  logic [USED_W-1:0]    used_nxt;

  logic              hit;
  logic [SLOT_W-1:0] hit_slot;
  logic              tfull;
  logic              claim;
  logic [SLOT_W-1:0] new_slot;

  // port lookup, slots are unique so first match is the only match
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (key_vld_r[i] && key_r[i] == in_port && !hit) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  assign tfull    = !hit && (used_r == USED_W'(NUM_PORTS));
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign claim    = q_push && in_cmd == CMD_RECV && !hit && !tfull;
  assign new_slot = used_r[SLOT_W-1:0];

  always_comb begin
    q_req.cmd     = in_cmd;
    q_req.known   = hit;
    q_req.tfull   = tfull;
    q_req.slot    = hit ? hit_slot : new_slot;
    q_req.seq     = in_seq;
    q_req.payload = in_payload;
  end

  always_comb begin
    key_vld_nxt = key_vld_r;
    used_nxt    = used_r;
    if (claim) begin
      key_vld_nxt[new_slot] = 1'b1;
      used_nxt              = used_r + USED_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_vld_r <= '0;
      used_r    <= '0;
    end else begin
      key_vld_r <= key_vld_nxt;
      used_r    <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      key_r[new_slot] <= in_port;
    end
  end

endmodule

// File: rtl/core/rps_queue.sv
module rps_queue import rps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output req_t head,
  output logic full,
  output logic empty
);

  req_t       slot_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_req;
    end
  end

endmodule

// File: rtl/core/rps_back.sv
`include "assert_macros.svh"

module rps_back import rps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  req_t             q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output status_t          out_status,
  output logic [SEQ_W-1:0] out_seq,
  output logic [REF_W-1:0] out_payload,
  output logic [CNT_W-1:0] out_count,
  output logic             out_last
);

  back_state_t state_r, state_nxt;
  req_t              cur_r, cur_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  status_t           res_r, res_nxt;

  logic [FILL_W-1:0] fill_r [NUM_PORTS];
  logic [SEQ_W-1:0]  last_r [NUM_PORTS];

  entry_t mem [MEM_DEPTH];
  entry_t rdata_r;

  // output register
  logic             out_valid_r;
  status_t          out_status_r;
  logic [SEQ_W-1:0] out_seq_r;
  logic [REF_W-1:0] out_payload_r;
  logic [CNT_W-1:0] out_count_r;
  logic             out_last_r;

  logic can_load;

  // datapath controls
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata;
  logic              fill_we;
  logic [SLOT_W-1:0] fill_slot;
  logic [FILL_W-1:0] fill_val;
  logic              last_we;
  logic              out_load;
  status_t           ld_status;
  logic [SEQ_W-1:0]  ld_seq;
  logic [REF_W-1:0]  ld_payload;
  logic [CNT_W-1:0]  ld_count;
  logic              ld_last;

  // head classification
  logic [FILL_W-1:0] h_fill;
  logic              h_stale, h_qfull, h_ins, h_drain_go;
  logic [FILL_W-1:0] cur_fill;
  logic [FILL_W-1:0] idx_inc;
  logic              rd_greater;
  entry_t            new_entry;

  assign can_load   = !out_valid_r || out_ready;
  assign h_fill     = q_head.known ? fill_r[q_head.slot] : '0;
  assign h_stale    = q_head.known && (q_head.seq <= last_r[q_head.slot]);
  assign h_qfull    = q_head.known && (h_fill == FILL_W'(QUEUE_DEPTH));
  assign h_ins      = !q_head.tfull && !h_stale && !h_qfull;
  assign h_drain_go = q_head.known && (h_fill != '0);
  assign cur_fill   = fill_r[cur_r.slot];
  assign idx_inc    = idx_r + FILL_W'(1);
  assign rd_greater = rdata_r.seq > cur_r.seq;
  assign new_entry  = '{seq: cur_r.seq, payload: cur_r.payload};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_head.cmd == CMD_DRAIN) begin
            state_nxt = h_drain_go ? B_DRN : B_RES;
          end else if (h_ins && h_fill != '0) begin
            state_nxt = B_INS;
          end else begin
            state_nxt = B_RES;
          end
        end
      end
      B_INS: begin
        if (rd_greater) begin
          state_nxt = (idx_r == FILL_W'(1)) ? B_INS0 : B_INS;
        end else begin
          state_nxt = B_RES;
        end
      end
      B_INS0: state_nxt = B_RES;
      B_RES: begin
        if (can_load) begin
          state_nxt = B_IDLE;
        end
      end
      B_DRN: begin
        if (can_load && idx_inc == cur_fill) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    q_pop      = 1'b0;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    waddr      = {cur_r.slot, idx_r[QIDX_W-1:0]};
    raddr      = {cur_r.slot, idx_r[QIDX_W-1:0]};
    wdata      = new_entry;
    fill_we    = 1'b0;
    fill_slot  = cur_r.slot;
    fill_val   = cur_fill + FILL_W'(1);
    last_we    = 1'b0;
    out_load   = 1'b0;
    ld_status  = res_r;
    ld_seq     = '0;
    ld_payload = '0;
    ld_count   = '0;
    ld_last    = 1'b1;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          if (q_head.cmd == CMD_DRAIN) begin
            res_nxt = ST_NOTHING;
            if (h_drain_go) begin
              mem_re  = 1'b1;
              raddr   = {q_head.slot, QIDX_W'(0)};
              idx_nxt = '0;
            end
          end else begin
            if (q_head.tfull) begin
              res_nxt = ST_TFULL;
            end else if (h_stale) begin
              res_nxt = ST_STALE;
            end else if (h_qfull) begin
              res_nxt = ST_QFULL;
            end else begin
              res_nxt = ST_QUEUED;
            end
            if (h_ins) begin
              if (h_fill == '0) begin
                // empty queue: store straight at the bottom
                mem_we    = 1'b1;
                waddr     = {q_head.slot, QIDX_W'(0)};
                wdata     = '{seq: q_head.seq, payload: q_head.payload};
                fill_we   = 1'b1;
                fill_slot = q_head.slot;
                fill_val  = FILL_W'(1);
              end else begin
                idx_nxt = h_fill;
                mem_re  = 1'b1;
                raddr   = {q_head.slot, QIDX_W'(h_fill - FILL_W'(1))};
              end
            end
          end
        end
      end
      B_INS: begin
        mem_we = 1'b1;
        if (rd_greater) begin
          // shift the larger entry up one place
          wdata = rdata_r;
          if (idx_r != FILL_W'(1)) begin
            mem_re  = 1'b1;
            raddr   = {cur_r.slot, QIDX_W'(idx_r - FILL_W'(2))};
            idx_nxt = idx_r - FILL_W'(1);
          end
        end else begin
          fill_we = 1'b1;
        end
      end
      B_INS0: begin
        mem_we  = 1'b1;
        waddr   = {cur_r.slot, QIDX_W'(0)};
        fill_we = 1'b1;
      end
      B_RES: begin
        out_load = can_load;
      end
      B_DRN: begin
        if (can_load) begin
          out_load   = 1'b1;
          ld_status  = ST_DRAINED;
          ld_seq     = rdata_r.seq;
          ld_payload = rdata_r.payload;
          ld_count   = CNT_W'(idx_inc);
          ld_last    = idx_inc == cur_fill;
          last_we    = 1'b1;
          if (idx_inc == cur_fill) begin
            fill_we  = 1'b1;
            fill_val = '0;
          end else begin
            mem_re  = 1'b1;
            raddr   = {cur_r.slot, idx_inc[QIDX_W-1:0]};
            idx_nxt = idx_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        fill_r[i] <= '0;
        last_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (fill_we) begin
        fill_r[fill_slot] <= fill_val;
      end
      if (last_we) begin
        last_r[cur_r.slot] <= rdata_r.seq;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_status_r  <= ld_status;
      out_seq_r     <= ld_seq;
      out_payload_r <= ld_payload;
      out_count_r   <= ld_count;
      out_last_r    <= ld_last;
    end
  end

  // per-slot queue storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_seq     = out_seq_r;
  assign out_payload = out_payload_r;
  assign out_count   = out_count_r;
  assign out_last    = out_last_r;

  `RPS_ASSERT(a_drn_nonempty, clk, rst_n, (state_r == B_DRN) |-> (idx_r < cur_fill), "drain index past fill")
  `RPS_ASSERT(a_ins_room, clk, rst_n, (state_r == B_INS) |-> (cur_fill < FILL_W'(QUEUE_DEPTH) && idx_r != '0), "insert into full queue")
  `RPS_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_seq_r) && $stable(out_count_r)), "stalled result lost")

endmodule

// File: rtl/core/per_port_packet_resequencer_core.sv
// Channel   | Dir | Signals                          | Contents (LSB first)
// ----------+-----+----------------------------------+--------------------------------------
// in        | in  | in_tvalid/tready/tdata/tuser     | tdata: port, seq, payload_ref; tuser: cmd
// out       | out | out_tvalid/tready/tdata/tuser/   | tdata: seq_res, payload_ref_res,
//           |     | tlast                            | drained_count; tuser: status
//
// Back end: a receive queued behind stored entries shifts up each stored entry with a larger
// sequence number; the insertion walk shifts one entry per cycle through the queue memory
// (one read and one write per cycle). A drain delivers its port's stored requests one at a time.
// Reset: rst_n, synchronous, clears the port table, fill counts and last-drained numbers;
// queue memory is not cleared and needs no clearing pass.
// Stalls: a 2-deep request queue parts the lookup front from the queue engine, and
// an output register holds a result while out_tready is low.
module per_port_packet_resequencer_core import rps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] port, [31:16] seq, [47:32] payload_ref
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] seq_res, [31:16] payload_ref_res,
                                  // [38:32] drained_count, [39] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);

  logic q_full, q_empty, q_push, q_pop;
  req_t push_req, head;

  status_t          st;
  logic [SEQ_W-1:0] seq_res;
  logic [REF_W-1:0] ref_res;
  logic [CNT_W-1:0] cnt_res;

  // front: port lookup and slot claim
  rps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_cmd     (cmd_t'(in_tuser)),
    .in_port    (in_tdata[15:0]),
    .in_seq     (in_tdata[31:16]),
    .in_payload (in_tdata[47:32]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_req      (push_req)
  );

  rps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: sorted insert per port and in-order drain
  rps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (head),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (st),
    .out_seq     (seq_res),
    .out_payload (ref_res),
    .out_count   (cnt_res),
    .out_last    (out_tlast)
  );

  assign out_tdata = {1'b0, cnt_res, ref_res, seq_res};
  assign out_tuser = st;

endmodule

// File: tb/tb_per_port_packet_resequencer_core.sv
`timescale 1ns / 1ps

module tb_per_port_packet_resequencer_core;
  import rps_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int POOL_N      = 14;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] pay;
  } pkt_t;

  typedef struct {
    status_t     st;
    logic [15:0] seq;
    logic [15:0] pay;
    logic [6:0]  cnt;
    logic        lst;
  } result_t;

  typedef struct {
    cmd_t        cmd;
    logic [15:0] port;
    logic [15:0] seq;
    logic [15:0] pay;
    bit          known_st;   // status below is typed in
    status_t     st;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // resequencer shadow state
  bit          slot_valid [NUM_PORTS];
  logic [15:0] slot_port  [NUM_PORTS];
  logic [15:0] last_drained [NUM_PORTS];
  pkt_t        held       [NUM_PORTS][QUEUE_DEPTH];
  int          held_n     [NUM_PORTS];
  int          slots_claimed;

  result_t     pending_results[$];
  int          mismatches;
  int          cycles = 0;
  int          idle_pct;
  int          stall_pct;
  logic [15:0] port_pool [POOL_N];
  dir_row_t    dir [14];

  always #5 clk = ~clk;

  per_port_packet_resequencer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  task automatic flag_error(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH @%0d: %s", cycles, what);
  endtask

  function automatic int slot_of(input logic [15:0] port);
    for (int i = 0; i < NUM_PORTS; i++)
      if (slot_valid[i] && slot_port[i] == port) return i;
    return -1;
  endfunction

  // work out what one accepted request produces; returns the first status
  function automatic status_t resequence(input cmd_t cmd, input logic [15:0] port,
                                         input logic [15:0] seq, input logic [15:0] pay);
    int      s;
    int      best;
    int      k;
    status_t st;
    pkt_t    e;
    s = slot_of(port);
    if (cmd == CMD_RECV) begin
      if (s >= 0) begin
        if (seq <= last_drained[s]) st = ST_STALE;
        else if (held_n[s] >= QUEUE_DEPTH) st = ST_QFULL;
        else begin
          held[s][held_n[s]] = '{seq, pay};
          held_n[s]++;
          st = ST_QUEUED;
        end
      end else if (slots_claimed >= NUM_PORTS) begin
        st = ST_TFULL;
      end else begin
        s = slots_claimed;
        slot_valid[s] = 1'b1;
        slot_port[s] = port;
        held[s][0] = '{seq, pay};
        held_n[s] = 1;
        slots_claimed++;
        st = ST_QUEUED;
      end
      pending_results.push_back('{st, 16'h0, 16'h0, 7'd0, 1'b1});
      return st;
    end
    if (s < 0 || held_n[s] == 0) begin
      pending_results.push_back('{ST_NOTHING, 16'h0, 16'h0, 7'd0, 1'b1});
      return ST_NOTHING;
    end
    // smallest sequence first, earliest arrival wins a tie
    k = 0;
    while (held_n[s] > 0) begin
      best = 0;
      for (int i = 1; i < held_n[s]; i++)
        if (held[s][i].seq < held[s][best].seq) best = i;
      e = held[s][best];
      for (int i = best; i + 1 < held_n[s]; i++) held[s][i] = held[s][i+1];
      held_n[s]--;
      k++;
      last_drained[s] = e.seq;
      pending_results.push_back('{ST_DRAINED, e.seq, e.pay, 7'(k), held_n[s] == 0});
    end
    return ST_DRAINED;
  endfunction

  // one request, with random idle cycles in front of it
  task automatic send_req(input cmd_t cmd, input logic [15:0] port,
                          input logic [15:0] seq, input logic [15:0] pay,
                          output status_t first_st);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pay, seq, port};
    do @(posedge clk); while (!in_tready);
    first_st = resequence(cmd, port, seq, pay);
  endtask

  // mostly a number above the port's last drained one, sometimes anything
  function automatic logic [15:0] pick_seq(input logic [15:0] port);
    int s;
    int v;
    s = slot_of(port);
    if ($urandom_range(99) < 25 || s < 0) return 16'($urandom);
    v = int'(last_drained[s]) + $urandom_range(1, 300);
    return (v > 16'hFFFF) ? 16'hFFFF : 16'(v);
  endfunction

  // result check and random back-pressure
  always @(posedge clk) begin
    result_t x;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result status=%0d tdata=%h", out_tuser, out_tdata));
      end else begin
        x = pending_results.pop_front();
        if (out_tuser !== x.st || out_tdata[15:0] !== x.seq ||
            out_tdata[31:16] !== x.pay || out_tdata[38:32] !== x.cnt ||
            out_tlast !== x.lst)
          flag_error($sformatf(
            "exp st=%0d seq=%h pay=%h cnt=%0d last=%b, got st=%0d seq=%h pay=%h cnt=%0d last=%b",
            x.st, x.seq, x.pay, x.cnt, x.lst, out_tuser, out_tdata[15:0],
            out_tdata[31:16], out_tdata[38:32], out_tlast));
      end
    end
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** per_port_packet_resequencer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    status_t     st;
    logic [15:0] p;
    int          n;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    slots_claimed = 0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_port[i] = '0;
      last_drained[i] = '0;
      held_n[i] = 0;
    end
    port_pool[0] = 16'hFFFF;
    port_pool[1] = 16'h0000;
    for (int i = 2; i < POOL_N; i++) port_pool[i] = 16'($urandom);

    // edge cases: empty, stale, ties, unknown port, seq extremes
    dir[0]  = '{CMD_DRAIN, 16'h0000, 16'h0000, 16'h0000, 1, ST_NOTHING};
    dir[1]  = '{CMD_RECV,  16'hFFFF, 16'h0005, 16'hAAAA, 1, ST_QUEUED};
    dir[2]  = '{CMD_RECV,  16'hFFFF, 16'h0000, 16'h5555, 1, ST_STALE};
    dir[3]  = '{CMD_RECV,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1, ST_QUEUED};
    dir[4]  = '{CMD_RECV,  16'hFFFF, 16'h0005, 16'h0001, 1, ST_QUEUED};
    dir[5]  = '{CMD_RECV,  16'hFFFF, 16'h0003, 16'h0000, 1, ST_QUEUED};
    dir[6]  = '{CMD_DRAIN, 16'hFFFF, 16'h0000, 16'h0000, 0, ST_DRAINED};
    dir[7]  = '{CMD_RECV,  16'hFFFF, 16'h8000, 16'h0000, 1, ST_STALE};
    dir[8]  = '{CMD_DRAIN, 16'hFFFF, 16'h0000, 16'h0000, 1, ST_NOTHING};
    dir[9]  = '{CMD_RECV,  16'h0000, 16'h0000, 16'h0000, 1, ST_QUEUED};
    dir[10] = '{CMD_RECV,  16'h0000, 16'h0001, 16'hFFFF, 1, ST_QUEUED};
    dir[11] = '{CMD_DRAIN, 16'h1234, 16'hFFFF, 16'hFFFF, 1, ST_NOTHING};
    dir[12] = '{CMD_DRAIN, 16'h0000, 16'h0000, 16'h0000, 0, ST_DRAINED};
    dir[13] = '{CMD_RECV,  16'h0000, 16'h0001, 16'h1111, 1, ST_STALE};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir[i]) begin
      send_req(dir[i].cmd, dir[i].port, dir[i].seq, dir[i].pay, st);
      if (dir[i].known_st && st != dir[i].st)
        flag_error($sformatf("row %0d: status %0d, table says %0d", i, st, dir[i].st));
    end

    // fill one queue past its depth, then drain it whole
    send_req(CMD_DRAIN, 16'h0000, 16'h0, 16'h0, st);
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      send_req(CMD_RECV, 16'h0000, 16'($urandom_range(2, 16'h3FFF)), 16'($urandom), st);
    send_req(CMD_DRAIN, 16'h0000, 16'h0, 16'h0, st);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      n = 0;
      while (n < 22) begin
        p = ($urandom_range(99) < 80) ? port_pool[$urandom_range(POOL_N - 1)]
                                      : 16'($urandom);
        if ($urandom_range(99) < 25)
          send_req(CMD_DRAIN, p, 16'($urandom), 16'($urandom), st);
        else
          send_req(CMD_RECV, p, pick_seq(p), 16'($urandom), st);
        n++;
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("** per_port_packet_resequencer_core: PASSED **");
    end else begin
      $display("** per_port_packet_resequencer_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rps_pkg.sv
rtl/core/rps_front.sv
rtl/core/rps_queue.sv
rtl/core/rps_back.sv
rtl/core/per_port_packet_resequencer_core.sv
tb/tb_per_port_packet_resequencer_core.sv
